FILE: hdl/srp_pkg.sv
// shared types and constants for the status report parser
package srp_pkg;

  localparam int unsigned MAX_PATTERN_BITS_DEF = 1024;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ACK,
    PH_LEN,
    PH_PAT,
    PH_CNT,
    PH_TXID,
    PH_TXLQ
  } phase_t;

  localparam logic [2:0] KIND_NODE_ID  = 3'd0;
  localparam logic [2:0] KIND_ACK_NUM  = 3'd1;
  localparam logic [2:0] KIND_PAT_LEN  = 3'd2;
  localparam logic [2:0] KIND_ACK_BIT  = 3'd3;
  localparam logic [2:0] KIND_TX_COUNT = 3'd4;
  localparam logic [2:0] KIND_TX_ENTRY = 3'd5;
  localparam logic [2:0] KIND_LEN_ERR  = 3'd6;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [31:0] field_value;
    logic [9:0]  bit_index;
    logic [7:0]  tx_id;
    logic [7:0]  link_quality;
    logic        run_last;
    logic        packet_done;
  } out_t;

  // first result of one byte plus the pattern bits that follow it
  typedef struct packed {
    logic       has_rec;
    out_t       rec;
    logic [2:0] extra;
    logic [6:0] pat_rest;
  } job_t;

endpackage

FILE: hdl/srp_decode.sv
// parse state machine: advances per byte and builds the first result
module srp_decode import srp_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BITS = MAX_PATTERN_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  byte_in,
  output job_t job
);

  localparam int unsigned REM_W = $clog2(MAX_PATTERN_BITS + 1);

  phase_t           phase_r, phase_nxt, cur_phase;
  logic [1:0]       bif_r, bif_nxt;
  logic [31:0]      fa_r, fa_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [9:0]       nbi_r, nbi_nxt;
  logic [7:0]       ent_r, ent_nxt;
  logic [7:0]       held_r, held_nxt;

  logic [7:0]  b;
  logic [31:0] asm_val;
  logic        asm_done;
  logic        len_err;
  logic [3:0]  take;
  logic [7:0]  ent_dec;

  assign b         = byte_in.report_byte;
  assign cur_phase = byte_in.packet_start ? PH_IDLE : phase_r;
  assign asm_val   = ((bif_r == 2'd0) ? 32'd0 : fa_r) | (32'(b) << {bif_r, 3'b000});
  assign asm_done  = (bif_r == 2'd3);
  assign len_err   = asm_val > 32'(MAX_PATTERN_BITS);
  assign take      = (rem_r < REM_W'(8)) ? 4'(rem_r) : 4'd8;
  assign ent_dec   = ent_r - 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (cur_phase)
        PH_IDLE: phase_nxt = PH_ACK;
        PH_ACK:  if (asm_done) phase_nxt = PH_LEN;
        PH_LEN: begin
          if (asm_done) begin
            if (len_err) phase_nxt = PH_IDLE;
            else if (asm_val == 32'd0) phase_nxt = PH_CNT;
            else phase_nxt = PH_PAT;
          end
        end
        PH_PAT:  if (rem_r == REM_W'(take)) phase_nxt = PH_CNT;
        PH_CNT:  phase_nxt = (b == 8'd0) ? PH_IDLE : PH_TXID;
        PH_TXID: phase_nxt = PH_TXLQ;
        PH_TXLQ: phase_nxt = (ent_dec == 8'd0) ? PH_IDLE : PH_TXID;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    bif_nxt  = bif_r;
    fa_nxt   = fa_r;
    rem_nxt  = rem_r;
    nbi_nxt  = nbi_r;
    ent_nxt  = ent_r;
    held_nxt = held_r;
    job      = '0;
    job.rec.run_last = 1'b1;
    if (fire) begin
      case (cur_phase)
        PH_IDLE: begin
          bif_nxt = 2'd0;
          job.has_rec = 1'b1;
          job.rec.record_kind = KIND_NODE_ID;
          job.rec.field_value = 32'(b);
        end
        PH_ACK: begin
          bif_nxt = bif_r + 2'd1;
          fa_nxt  = asm_val;
          if (asm_done) begin
            job.has_rec = 1'b1;
            job.rec.record_kind = KIND_ACK_NUM;
            job.rec.field_value = asm_val;
          end
        end
        PH_LEN: begin
          bif_nxt = bif_r + 2'd1;
          fa_nxt  = asm_val;
          if (asm_done) begin
            job.has_rec = 1'b1;
            job.rec.field_value = asm_val;
            if (len_err) begin
              job.rec.record_kind = KIND_LEN_ERR;
            end else begin
              job.rec.record_kind = KIND_PAT_LEN;
              rem_nxt = REM_W'(asm_val);
              nbi_nxt = 10'd0;
            end
          end
        end
        PH_PAT: begin
          rem_nxt = rem_r - REM_W'(take);
          nbi_nxt = nbi_r + 10'(take);
          job.has_rec = 1'b1;
          job.rec.record_kind = KIND_ACK_BIT;
          job.rec.field_value = 32'(b[7]);
          job.rec.bit_index   = nbi_r;
          job.rec.run_last    = (take == 4'd1);
          job.extra           = 3'(take - 4'd1);
          job.pat_rest        = b[6:0];
        end
        PH_CNT: begin
          ent_nxt = b;
          job.has_rec = 1'b1;
          job.rec.record_kind = KIND_TX_COUNT;
          job.rec.field_value = 32'(b);
          job.rec.packet_done = (b == 8'd0);
        end
        PH_TXID: begin
          held_nxt = b;
        end
        PH_TXLQ: begin
          ent_nxt = ent_dec;
          job.has_rec = 1'b1;
          job.rec.record_kind  = KIND_TX_ENTRY;
          job.rec.tx_id        = held_r;
          job.rec.link_quality = b;
          job.rec.packet_done  = (ent_dec == 8'd0);
        end
        default: begin
          job.has_rec = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bif_r   <= 2'd0;
      fa_r    <= 32'd0;
      rem_r   <= '0;
      nbi_r   <= 10'd0;
      ent_r   <= 8'd0;
      held_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      fa_r    <= fa_nxt;
      rem_r   <= rem_nxt;
      nbi_r   <= nbi_nxt;
      ent_r   <= ent_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: hdl/status_report_parser.sv
// Status report parser: takes one packet byte per transaction on in_ and gives result records
// on out_. A byte is held in an input register and then decoded combinationally; non-pattern
// bytes give at most one record, a pattern byte gives up to eight ack bit records, one per
// cycle from the output register while out_ready is high, so a byte that gives records holds
// the output stage until its last record is taken, and a byte that gives none passes straight through.
// The input register takes the next byte while a record waits to be taken. Set packet_start
// on a byte to restart the parse with that byte as node id.
module status_report_parser import srp_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BITS = MAX_PATTERN_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic       a_valid_r, a_valid_nxt;
  in_t        a_data_r, a_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;
  logic [2:0] extra_r, extra_nxt;
  logic [6:0] pat_r, pat_nxt;
  logic       b_free;
  logic       fire;
  logic       advance;
  job_t       job;

  assign b_free   = !out_valid_r || (out_ready && out_data_r.run_last);
  assign fire     = a_valid_r && b_free;
  assign advance  = out_valid_r && out_ready && !out_data_r.run_last;
  assign in_ready = !a_valid_r || b_free;

  srp_decode #(.MAX_PATTERN_BITS(MAX_PATTERN_BITS)) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (a_data_r),
    .job     (job)
  );

  // input register
  always_comb begin
    a_valid_nxt = a_valid_r;
    a_data_nxt  = a_data_r;
    if (in_valid && in_ready) begin
      a_valid_nxt = 1'b1;
      a_data_nxt  = in_data;
    end else if (fire) begin
      a_valid_nxt = 1'b0;
    end
  end

  // result register and pattern bit emitter
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    extra_nxt     = extra_r;
    pat_nxt       = pat_r;
    if (fire) begin
      out_valid_nxt = job.has_rec;
      if (job.has_rec) begin
        out_data_nxt = job.rec;
        extra_nxt    = job.extra;
        pat_nxt      = job.pat_rest;
      end
    end else if (advance) begin
      out_data_nxt.field_value = 32'(pat_r[6]);
      out_data_nxt.bit_index   = out_data_r.bit_index + 10'd1;
      out_data_nxt.run_last    = (extra_r == 3'd1);
      extra_nxt                = extra_r - 3'd1;
      pat_nxt                  = {pat_r[5:0], 1'b0};
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_data_r   <= a_data_nxt;
    out_data_r <= out_data_nxt;
    extra_r    <= extra_nxt;
    pat_r      <= pat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
